// File: hw/rtl/source_byte_tokenizer_assert.svh
// Assertion macros shared by the tokenizer checker.
`ifndef SOURCE_BYTE_TOKENIZER_ASSERT_SVH
`define SOURCE_BYTE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define SBT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// Next-cycle implication, disabled while rst is high.
`define SBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

// File: hw/rtl/sbt_pkg.sv
// Types, character classes and token codes for the source byte tokenizer.
package sbt_pkg;

   typedef enum logic [4:0] {
      TK_LET     = 5'd0,
      TK_FN      = 5'd1,
      TK_IF      = 5'd2,
      TK_ELSE    = 5'd3,
      TK_FOR     = 5'd4,
      TK_IDENT   = 5'd5,
      TK_INT     = 5'd6,
      TK_STRING  = 5'd7,
      TK_LBRACE  = 5'd8,
      TK_RBRACE  = 5'd9,
      TK_LPAREN  = 5'd10,
      TK_RPAREN  = 5'd11,
      TK_COLON   = 5'd12,
      TK_SEMI    = 5'd13,
      TK_ASSIGN  = 5'd14,
      TK_PLUS    = 5'd15,
      TK_MINUS   = 5'd16,
      TK_MUL     = 5'd17,
      TK_DIV     = 5'd18,
      TK_DOT     = 5'd19,
      TK_EOF     = 5'd20,
      TK_UNKNOWN = 5'd21
   } token_kind_type;

   typedef enum logic [5:0] {
      M_IDLE    = 6'b000001,
      M_SLASH   = 6'b000010,
      M_COMMENT = 6'b000100,
      M_WORD    = 6'b001000,
      M_NUMBER  = 6'b010000,
      M_STRING  = 6'b100000
   } lex_mode_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    line;
      logic [15:0]    col;
      logic [31:0]    offset;
      logic [15:0]    length;
      logic           last;
   } token_type;

   localparam logic [7:0]  CHAR_LF    = 8'h0A;
   localparam logic [7:0]  CHAR_SLASH = 8'h2F;
   localparam logic [7:0]  CHAR_QUOTE = 8'h22;
   localparam logic [15:0] LEN_MAX    = 16'hFFFF;

   // First bytes of a word, first byte in the low byte.
   localparam logic [31:0] KW_FN   = 32'h0000_6E66;
   localparam logic [31:0] KW_IF   = 32'h0000_6669;
   localparam logic [31:0] KW_LET  = 32'h0074_656C;
   localparam logic [31:0] KW_FOR  = 32'h0072_6F66;
   localparam logic [31:0] KW_ELSE = 32'h6573_6C65;

   function automatic logic is_space(input logic [7:0] b);
      return (b inside {[8'h09:8'h0D], 8'h20});
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b inside {[8'h30:8'h39]});
   endfunction

   function automatic logic is_word_start(input logic [7:0] b);
      return (b inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F});
   endfunction

   function automatic logic is_word(input logic [7:0] b);
      return is_word_start(b) || is_digit(b);
   endfunction

   function automatic token_kind_type punct_kind(input logic [7:0] b);
      token_kind_type k;
      case (b)
         8'h7B: k = TK_LBRACE;
         8'h7D: k = TK_RBRACE;
         8'h28: k = TK_LPAREN;
         8'h29: k = TK_RPAREN;
         8'h3A: k = TK_COLON;
         8'h3B: k = TK_SEMI;
         8'h3D: k = TK_ASSIGN;
         8'h2B: k = TK_PLUS;
         8'h2D: k = TK_MINUS;
         8'h2A: k = TK_MUL;
         8'h2E: k = TK_DOT;
         default: k = TK_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic token_kind_type word_kind(input logic [15:0] len,
                                                input logic [31:0] prefix);
      token_kind_type k;
      k = TK_IDENT;
      if (len == 16'd2 && prefix == KW_FN) begin
         k = TK_FN;
      end else if (len == 16'd2 && prefix == KW_IF) begin
         k = TK_IF;
      end else if (len == 16'd3 && prefix == KW_LET) begin
         k = TK_LET;
      end else if (len == 16'd3 && prefix == KW_FOR) begin
         k = TK_FOR;
      end else if (len == 16'd4 && prefix == KW_ELSE) begin
         k = TK_ELSE;
      end
      return k;
   endfunction

endpackage

// File: hw/rtl/source_byte_tokenizer.sv
// Streaming lexer: one source byte per word in, position-tagged tokens out.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_action, req_source_byte
//   rsp      out  rsp_valid/rsp_ready    rsp_token_*, rsp_run_last
//
// Each accepted byte updates the lexer state in the same cycle and pushes
// 0, 1 or 2 tokens into a 4-entry result queue; a byte can be taken every
// cycle while req_ready is high. The result side drains one token per cycle
// while rsp_ready is high, so the queue sets the rate when bytes average more
// than one token. req_ready is high while the queue has room for two tokens.
// Synchronous reset empties the queue and returns the lexer to line 1, column 1.
module source_byte_tokenizer #(
   parameter int OFFSET_BITS = 32,
   parameter int LINE_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_source_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_line,
   output logic [15:0] rsp_token_col,
   output logic [31:0] rsp_token_offset,
   output logic [15:0] rsp_token_length,
   output logic        rsp_run_last
);
   import sbt_pkg::*;

   typedef logic [LINE_BITS-1:0]   line_type;
   typedef logic [OFFSET_BITS-1:0] off_type;

   lex_mode_type mode_ff, mode_in;
   line_type     line_ff, line_in;
   line_type     col_ff, col_in;
   off_type      off_ff, off_in;
   line_type     anchor_col_ff, anchor_col_in;
   off_type      start_off_ff, start_off_in;
   logic [15:0]  len_ff, len_in;
   logic [31:0]  prefix_ff, prefix_in;

   token_type    queue_ff [4];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [2:0]   count_ff, count_in;

   logic         accept, pop, is_end, run_idle;
   logic [7:0]   b;
   line_type     line_inc, col_inc, col_base, col_base_inc;
   off_type      off_inc;
   logic [15:0]  len_inc;
   logic         pend_valid, sec_valid;
   token_type    pend_tok, sec_tok, first_tok, second_tok;
   logic [1:0]   n_push;

   function automatic line_type sat_inc(input line_type v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [15:0] sat16(input line_type v);
      return (64'(v) > 64'hFFFF) ? 16'hFFFF : 16'(v);
   endfunction

   function automatic logic [31:0] sat32(input off_type v);
      return (64'(v) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
   endfunction

   assign req_ready = (count_ff < 3'd3);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = (count_ff != 3'd0);
   assign pop       = rsp_valid & rsp_ready;

   always_comb begin
      b            = req_source_byte;
      is_end       = req_action | (b == 8'h00);
      line_inc     = sat_inc(line_ff);
      col_inc      = sat_inc(col_ff);
      col_base     = (mode_ff == M_SLASH) ? col_inc : col_ff;
      col_base_inc = sat_inc(col_base);
      off_inc      = (&off_ff) ? off_ff : off_ff + 1'b1;
      len_inc      = (len_ff == LEN_MAX) ? len_ff : len_ff + 16'd1;

      mode_in       = mode_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      off_in        = off_ff;
      anchor_col_in = anchor_col_ff;
      start_off_in  = start_off_ff;
      len_in        = len_ff;
      prefix_in     = prefix_ff;
      pend_valid    = 1'b0;
      sec_valid     = 1'b0;
      run_idle      = 1'b0;

      // pending slash, word, number or string
      pend_tok.line   = sat16(line_ff);
      pend_tok.col    = sat16(anchor_col_ff);
      pend_tok.offset = sat32(start_off_ff);
      pend_tok.length = len_ff;
      pend_tok.last   = 1'b0;
      case (mode_ff)
         M_SLASH: begin
            pend_tok.kind   = TK_DIV;
            pend_tok.length = 16'd1;
         end
         M_WORD:   pend_tok.kind = word_kind(len_ff, prefix_ff);
         M_NUMBER: pend_tok.kind = TK_INT;
         M_STRING: pend_tok.kind = TK_STRING;
         default:  pend_tok.kind = TK_IDENT;
      endcase

      sec_tok.kind   = TK_EOF;
      sec_tok.line   = sat16(line_ff);
      sec_tok.col    = sat16(col_base);
      sec_tok.offset = sat32(off_ff);
      sec_tok.length = 16'd0;
      sec_tok.last   = 1'b0;

      if (is_end) begin
         pend_valid    = (mode_ff == M_SLASH) || (mode_ff == M_WORD) ||
                         (mode_ff == M_NUMBER) || (mode_ff == M_STRING);
         sec_valid     = 1'b1;
         mode_in       = M_IDLE;
         line_in       = line_type'(1);
         col_in        = line_type'(1);
         off_in        = '0;
         anchor_col_in = line_type'(1);
         start_off_in  = '0;
         len_in        = 16'd0;
         prefix_in     = 32'd0;
      end else begin
         off_in = off_inc;
         case (mode_ff)
            M_SLASH: begin
               if (b == CHAR_SLASH) begin
                  mode_in = M_COMMENT;
               end else begin
                  pend_valid = 1'b1;
                  run_idle   = 1'b1;
               end
            end
            M_COMMENT: begin
               if (b == CHAR_LF) begin
                  line_in = line_inc;
                  col_in  = line_type'(1);
                  mode_in = M_IDLE;
               end
            end
            M_WORD, M_NUMBER: begin
               if ((mode_ff == M_WORD) ? is_word(b) : is_digit(b)) begin
                  if (len_ff < 16'd4) begin
                     prefix_in = prefix_ff | ({24'd0, b} << {len_ff[1:0], 3'b000});
                  end
                  len_in = len_inc;
                  col_in = col_inc;
               end else begin
                  pend_valid = 1'b1;
                  run_idle   = 1'b1;
               end
            end
            M_STRING: begin
               if (b == CHAR_QUOTE) begin
                  col_in     = col_inc;
                  pend_valid = 1'b1;
                  mode_in    = M_IDLE;
               end else begin
                  if (b == CHAR_LF) begin
                     line_in = line_inc;
                     col_in  = line_type'(1);
                  end else begin
                     col_in = col_inc;
                  end
                  len_in = len_inc;
               end
            end
            default: run_idle = 1'b1;
         endcase

         if (run_idle) begin
            mode_in = M_IDLE;
            col_in  = col_base;
            if (is_space(b)) begin
               if (b == CHAR_LF) begin
                  line_in = line_inc;
                  col_in  = line_type'(1);
               end else begin
                  col_in = col_base_inc;
               end
            end else if (b == CHAR_SLASH) begin
               anchor_col_in = col_base;
               start_off_in  = off_ff;
               mode_in       = M_SLASH;
            end else if (b == CHAR_QUOTE) begin
               anchor_col_in = col_base;
               start_off_in  = off_inc;
               len_in        = 16'd0;
               col_in        = col_base_inc;
               mode_in       = M_STRING;
            end else if (is_word_start(b) || is_digit(b)) begin
               anchor_col_in = col_base;
               start_off_in  = off_ff;
               len_in        = 16'd1;
               prefix_in     = {24'd0, b};
               col_in        = col_base_inc;
               mode_in       = is_digit(b) ? M_NUMBER : M_WORD;
            end else begin
               sec_valid      = 1'b1;
               sec_tok.kind   = punct_kind(b);
               sec_tok.length = (sec_tok.kind == TK_UNKNOWN) ? 16'd0 : 16'd1;
               col_in         = col_base_inc;
            end
         end
      end

      n_push          = {1'b0, pend_valid} + {1'b0, sec_valid};
      first_tok       = pend_valid ? pend_tok : sec_tok;
      first_tok.last  = (n_push == 2'd1);
      second_tok      = sec_tok;
      second_tok.last = 1'b1;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff - {2'b00, pop};
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + n_push;
         count_in  = count_ff + {1'b0, n_push} - {2'b00, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= M_IDLE;
         line_ff       <= line_type'(1);
         col_ff        <= line_type'(1);
         off_ff        <= '0;
         anchor_col_ff <= line_type'(1);
         start_off_ff  <= '0;
         len_ff        <= 16'd0;
         prefix_ff     <= 32'd0;
         wr_ptr_ff     <= 2'd0;
         rd_ptr_ff     <= 2'd0;
         count_ff      <= 3'd0;
      end else begin
         if (accept) begin
            mode_ff       <= mode_in;
            line_ff       <= line_in;
            col_ff        <= col_in;
            off_ff        <= off_in;
            anchor_col_ff <= anchor_col_in;
            start_off_ff  <= start_off_in;
            len_ff        <= len_in;
            prefix_ff     <= prefix_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && n_push != 2'd0) begin
         queue_ff[wr_ptr_ff] <= first_tok;
      end
      if (accept && n_push == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= second_tok;
      end
   end

   assign rsp_token_kind   = queue_ff[rd_ptr_ff].kind;
   assign rsp_token_line   = queue_ff[rd_ptr_ff].line;
   assign rsp_token_col    = queue_ff[rd_ptr_ff].col;
   assign rsp_token_offset = queue_ff[rd_ptr_ff].offset;
   assign rsp_token_length = queue_ff[rd_ptr_ff].length;
   assign rsp_run_last     = queue_ff[rd_ptr_ff].last;

endmodule

// File: hw/rtl/sbt_checker.sv
// Port-level checks for the source byte tokenizer, bound to the top level.
`include "source_byte_tokenizer_assert.svh"

module sbt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_action,
   input logic [7:0]  req_source_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_token_kind,
   input logic [15:0] rsp_token_line,
   input logic [15:0] rsp_token_col,
   input logic [31:0] rsp_token_offset,
   input logic [15:0] rsp_token_length,
   input logic        rsp_run_last
);
   import sbt_pkg::*;

   logic eof_word;
   logic unk_word;

   assign eof_word = rsp_valid && (rsp_token_kind == TK_EOF);
   assign unk_word = rsp_valid && (rsp_token_kind == TK_UNKNOWN);

   `SBT_ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, !rsp_valid)
   `SBT_ASSERT_NOW(a_kind_range, clock, reset, rsp_valid, rsp_token_kind <= TK_UNKNOWN)
   `SBT_ASSERT_NOW(a_eof_closes_run, clock, reset, eof_word, rsp_run_last && rsp_token_length == 16'd0)
   `SBT_ASSERT_NOW(a_unknown_empty, clock, reset, unk_word, rsp_token_length == 16'd0 && rsp_token_line != 16'd0)
   `SBT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_token_offset))

endmodule

bind source_byte_tokenizer sbt_checker u_sbt_checker (.*);

// File: test/source_byte_tokenizer_test.sv
// Self-checking testbench for source_byte_tokenizer: directed table and random source text.
`timescale 1ns / 1ps

module source_byte_tokenizer_test;
   import sbt_pkg::*;

   localparam int DIR_ROWS     = 29;
   localparam int RANDOM_WORDS = 1750;
   localparam int QUIET_FROM   = 1350;

   typedef struct packed {
      logic       act;
      logic [7:0] b;
      logic       fixed;
      token_type  tok;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [7:0]  req_source_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_token_kind;
   logic [15:0] rsp_token_line;
   logic [15:0] rsp_token_col;
   logic [31:0] rsp_token_offset;
   logic [15:0] rsp_token_length;
   logic        rsp_run_last;

   // directed-row expectation, travels with the word it belongs to
   logic        row_fixed = 1'b0;
   token_type   row_token = '0;
   logic        idling = 1'b1;

   int          errors = 0;
   int          words_sent = 0;
   int          tokens_checked = 0;
   int          stall_left = 0;

   // lexer shadow state
   lex_mode_type lx_mode;
   logic [15:0]  ln, cl, anchor_col, run_len;
   logic [31:0]  offs, start_off, prefix;
   token_type    step_tok [2];
   int           step_n;
   token_type    tokens_due [$];

   source_byte_tokenizer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_source_byte (req_source_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_line  (rsp_token_line),
      .rsp_token_col   (rsp_token_col),
      .rsp_token_offset(rsp_token_offset),
      .rsp_token_length(rsp_token_length),
      .rsp_run_last    (rsp_run_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      if (errors <= 50) begin
         $display("%0t token %0d %s: got %0d, expected %0d", $time, tokens_checked, what,
                  got, want);
      end
   endtask

   // ---------------------------------------------------------------- predictor
   function automatic logic [15:0] bump(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic bit blank_byte(input logic [7:0] b);
      return b == " " || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic bit digit_byte(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit lead_byte(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic token_kind_type punct_token(input logic [7:0] b);
      case (b)
         "{": return TK_LBRACE;
         "}": return TK_RBRACE;
         "(": return TK_LPAREN;
         ")": return TK_RPAREN;
         ":": return TK_COLON;
         ";": return TK_SEMI;
         "=": return TK_ASSIGN;
         "+": return TK_PLUS;
         "-": return TK_MINUS;
         "*": return TK_MUL;
         ".": return TK_DOT;
         default: return TK_UNKNOWN;
      endcase
   endfunction

   function automatic token_kind_type word_token();
      if (run_len == 16'd2 && prefix == KW_FN) return TK_FN;
      if (run_len == 16'd2 && prefix == KW_IF) return TK_IF;
      if (run_len == 16'd3 && prefix == KW_LET) return TK_LET;
      if (run_len == 16'd3 && prefix == KW_FOR) return TK_FOR;
      if (run_len == 16'd4 && prefix == KW_ELSE) return TK_ELSE;
      return TK_IDENT;
   endfunction

   task automatic note(input token_kind_type k, input logic [15:0] line,
                       input logic [15:0] col, input logic [31:0] off, input logic [15:0] len);
      if (step_n < 2) begin
         step_tok[step_n] = '{kind: k, line: line, col: col, offset: off, length: len,
                              last: 1'b0};
         step_n++;
      end
   endtask

   task automatic lex_clear();
      lx_mode    = M_IDLE;
      ln         = 16'd1;
      cl         = 16'd1;
      offs       = 32'd0;
      anchor_col = 16'd1;
      start_off  = 32'd0;
      run_len    = 16'd0;
      prefix     = 32'd0;
   endtask

   task automatic open_run(input logic [7:0] b, input lex_mode_type m);
      anchor_col = cl;
      start_off  = offs;
      run_len    = 16'd1;
      prefix     = {24'd0, b};
      cl         = bump(cl);
      lx_mode    = m;
   endtask

   task automatic grow_run(input logic [7:0] b);
      if (run_len < 16'd4) prefix = prefix | ({24'd0, b} << (8 * run_len));
      if (run_len != LEN_MAX) run_len = run_len + 16'd1;
      cl = bump(cl);
   endtask

   task automatic flush_slash();
      note(TK_DIV, ln, anchor_col, start_off, 16'd1);
      cl = bump(cl);
   endtask

   task automatic lex_idle(input logic [7:0] b);
      token_kind_type k;
      lx_mode = M_IDLE;
      if (blank_byte(b)) begin
         if (b == CHAR_LF) begin
            ln = bump(ln);
            cl = 16'd1;
         end else begin
            cl = bump(cl);
         end
      end else if (b == CHAR_SLASH) begin
         anchor_col = cl;
         start_off  = offs;
         lx_mode    = M_SLASH;
      end else if (b == CHAR_QUOTE) begin
         anchor_col = cl;
         start_off  = (offs != 32'hFFFF_FFFF) ? offs + 32'd1 : offs;
         run_len    = 16'd0;
         cl         = bump(cl);
         lx_mode    = M_STRING;
      end else if (lead_byte(b)) begin
         open_run(b, M_WORD);
      end else if (digit_byte(b)) begin
         open_run(b, M_NUMBER);
      end else begin
         k = punct_token(b);
         note(k, ln, cl, offs, (k == TK_UNKNOWN) ? 16'd0 : 16'd1);
         cl = bump(cl);
      end
   endtask

   task automatic tokenize_word(input logic act, input logic [7:0] b, input logic fixed,
                                input token_type tok);
      int i;
      step_n = 0;
      if (act || b == 8'h00) begin
         case (lx_mode)
            M_SLASH:  flush_slash();
            M_WORD:   note(word_token(), ln, anchor_col, start_off, run_len);
            M_NUMBER: note(TK_INT, ln, anchor_col, start_off, run_len);
            M_STRING: note(TK_STRING, ln, anchor_col, start_off, run_len);
            default: ;
         endcase
         note(TK_EOF, ln, cl, offs, 16'd0);
         lex_clear();
      end else begin
         case (lx_mode)
            M_SLASH: begin
               if (b == CHAR_SLASH) begin
                  lx_mode = M_COMMENT;
               end else begin
                  flush_slash();
                  lex_idle(b);
               end
            end
            M_COMMENT: begin
               if (b == CHAR_LF) begin
                  ln      = bump(ln);
                  cl      = 16'd1;
                  lx_mode = M_IDLE;
               end
            end
            M_WORD: begin
               if (lead_byte(b) || digit_byte(b)) begin
                  grow_run(b);
               end else begin
                  note(word_token(), ln, anchor_col, start_off, run_len);
                  lex_idle(b);
               end
            end
            M_NUMBER: begin
               if (digit_byte(b)) begin
                  grow_run(b);
               end else begin
                  note(TK_INT, ln, anchor_col, start_off, run_len);
                  lex_idle(b);
               end
            end
            M_STRING: begin
               if (b == CHAR_QUOTE) begin
                  cl = bump(cl);
                  note(TK_STRING, ln, anchor_col, start_off, run_len);
                  lx_mode = M_IDLE;
               end else begin
                  if (b == CHAR_LF) begin
                     ln = bump(ln);
                     cl = 16'd1;
                  end else begin
                     cl = bump(cl);
                  end
                  if (run_len != LEN_MAX) run_len = run_len + 16'd1;
               end
            end
            default: lex_idle(b);
         endcase
         if (offs != 32'hFFFF_FFFF) offs = offs + 32'd1;
      end
      if (fixed) begin
         if (step_n == 0) report("directed row tokens", 0, 1);
         else step_tok[step_n - 1] = tok;
      end
      if (step_n > 0) step_tok[step_n - 1].last = 1'b1;
      for (i = 0; i < step_n; i++) tokens_due.push_back(step_tok[i]);
   endtask

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         lex_clear();
      end else begin
         if (req_valid && req_ready) begin
            tokenize_word(req_action, req_source_byte, row_fixed, row_token);
         end
         if (rsp_valid && rsp_ready) begin
            if (tokens_due.size() == 0) begin
               report("token with none due, kind", 32'(rsp_token_kind), 0);
            end else begin
               want = tokens_due.pop_front();
               if (rsp_token_kind !== want.kind) begin
                  report("kind", 32'(rsp_token_kind), 32'(want.kind));
               end
               if (rsp_token_line !== want.line) begin
                  report("line", 32'(rsp_token_line), 32'(want.line));
               end
               if (rsp_token_col !== want.col) begin
                  report("col", 32'(rsp_token_col), 32'(want.col));
               end
               if (rsp_token_offset !== want.offset) begin
                  report("offset", rsp_token_offset, want.offset);
               end
               if (rsp_token_length !== want.length) begin
                  report("length", 32'(rsp_token_length), 32'(want.length));
               end
               if (rsp_run_last !== want.last) begin
                  report("run_last", 32'(rsp_run_last), 32'(want.last));
               end
            end
            tokens_checked++;
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic stim_row_type free_row(input logic act, input logic [7:0] b);
      stim_row_type r;
      r     = '0;
      r.act = act;
      r.b   = b;
      return r;
   endfunction

   function automatic stim_row_type fixed_row(input logic act, input logic [7:0] b,
                                              input token_kind_type k,
                                              input logic [15:0] line,
                                              input logic [15:0] col,
                                              input logic [31:0] off,
                                              input logic [15:0] len);
      stim_row_type r;
      r       = free_row(act, b);
      r.fixed = 1'b1;
      r.tok   = '{kind: k, line: line, col: col, offset: off, length: len, last: 1'b1};
      return r;
   endfunction

   function automatic stim_row_type dir_row(input int i);
      case (i)
         0:  return fixed_row(1'b0, "{", TK_LBRACE, 16'd1, 16'd1, 32'd0, 16'd1);
         1:  return fixed_row(1'b0, 8'hFF, TK_UNKNOWN, 16'd1, 16'd2, 32'd1, 16'd0);
         2:  return free_row(1'b0, "l");
         3:  return free_row(1'b0, "e");
         4:  return free_row(1'b0, "t");
         5:  return fixed_row(1'b0, " ", TK_LET, 16'd1, 16'd3, 32'd2, 16'd3);
         6:  return free_row(1'b0, "a");
         7:  return free_row(1'b0, "7");
         8:  return free_row(1'b0, CHAR_SLASH);
         9:  return free_row(1'b0, CHAR_SLASH);
         10: return free_row(1'b0, "q");
         11: return free_row(1'b0, CHAR_LF);
         12: return free_row(1'b0, "4");
         13: return free_row(1'b0, "i");
         14: return free_row(1'b0, "f");
         15: return free_row(1'b0, CHAR_SLASH);
         16: return free_row(1'b1, 8'h41);
         17: return fixed_row(1'b0, 8'h00, TK_EOF, 16'd1, 16'd1, 32'd0, 16'd0);
         18: return free_row(1'b0, CHAR_QUOTE);
         19: return free_row(1'b0, CHAR_LF);
         20: return free_row(1'b1, 8'h00);
         21: return free_row(1'b0, "e");
         22: return free_row(1'b0, "l");
         23: return free_row(1'b0, "s");
         24: return free_row(1'b0, "e");
         25: return free_row(1'b0, 8'h00);
         26: return free_row(1'b0, CHAR_SLASH);
         27: return free_row(1'b0, CHAR_SLASH);
         default: return free_row(1'b1, 8'hBE);
      endcase
   endfunction

   function automatic logic [7:0] rand_word_byte(input bit lead);
      int v;
      v = $urandom_range(0, lead ? 52 : 62);
      if (v < 26) return 8'("a" + v);
      if (v < 52) return 8'("A" + (v - 26));
      if (v == 52) return "_";
      return 8'("0" + (v - 53));
   endfunction

   task automatic send_word(input stim_row_type r);
      if (idling && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= r.act;
      req_source_byte <= r.b;
      row_fixed       <= r.fixed;
      row_token       <= r.tok;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_word(free_row(1'b0, s[i]));
   endtask

   initial begin
      int          i, j, n, pick;
      string       s;
      logic [7:0]  c;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++) send_word(dir_row(i));

      while (words_sent < RANDOM_WORDS) begin
         if (words_sent > QUIET_FROM) idling <= 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            case ($urandom_range(0, 11))
               0:  s = "let";
               1:  s = "fn";
               2:  s = "for";
               3:  s = "if";
               4:  s = "else";
               5:  s = "le";
               6:  s = "lets";
               7:  s = "fnx";
               8:  s = "iF";
               9:  s = "els";
               10: s = "elsex";
               default: s = "for_1";
            endcase
            send_text(s);
         end else if (pick < 26) begin
            n = $urandom_range(1, 6);
            for (j = 0; j < n; j++) send_word(free_row(1'b0, rand_word_byte(j == 0)));
         end else if (pick < 36) begin
            n = $urandom_range(1, 5);
            for (j = 0; j < n; j++) begin
               send_word(free_row(1'b0, 8'("0" + $urandom_range(0, 9))));
            end
         end else if (pick < 44) begin
            send_word(free_row(1'b0, CHAR_QUOTE));
            n = $urandom_range(0, 6);
            for (j = 0; j < n; j++) begin
               if ($urandom_range(0, 7) == 0) c = CHAR_LF;
               else if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(1, 255));
               else c = 8'($urandom_range(32, 126));
               if (c == CHAR_QUOTE) c = "_";
               send_word(free_row(1'b0, c));
            end
            if ($urandom_range(0, 9) != 0) send_word(free_row(1'b0, CHAR_QUOTE));
         end else if (pick < 58) begin
            s = "{}():;=+-*.";
            send_word(free_row(1'b0, s[$urandom_range(0, 10)]));
         end else if (pick < 62) begin
            send_word(free_row(1'b0, CHAR_SLASH));
         end else if (pick < 67) begin
            send_text("//");
            n = $urandom_range(0, 8);
            for (j = 0; j < n; j++) begin
               c = 8'($urandom_range(1, 255));
               if (c == CHAR_LF) c = " ";
               send_word(free_row(1'b0, c));
            end
            if ($urandom_range(0, 9) != 0) send_word(free_row(1'b0, CHAR_LF));
         end else if (pick < 84) begin
            c = 8'($urandom_range(8, 13));
            if (c == 8'd8) c = " ";
            send_word(free_row(1'b0, c));
         end else if (pick < 96) begin
            send_word(free_row(1'b0, 8'($urandom_range(1, 255))));
         end else if (pick < 99) begin
            send_word(free_row(1'b1, 8'($urandom_range(0, 255))));
         end else begin
            send_word(free_row(1'b0, 8'h00));
         end
      end

      send_word(free_row(1'b1, 8'h00));
      req_valid <= 1'b0;

      while (tokens_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tokens_due.size() != 0) report("tokens never seen", tokens_due.size(), 0);

      $display("run covered %0d source words and %0d tokens from a directed table and",
               words_sent, tokens_checked);
      $display("random text with keywords, strings, comments and stalls on both sides");
      if (errors == 0) begin
         $display("source_byte_tokenizer_test: clean");
      end else begin
         $display("source_byte_tokenizer_test: errors");
      end
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("timeout with %0d tokens still due", tokens_due.size());
      $display("source_byte_tokenizer_test: errors");
      $finish;
   end

endmodule
